// ===== rtl/qhp_pkg.sv =====
package qhp_pkg;

  // Table geometry.
  localparam int SYMBOLS         = 256;
  localparam int MAX_CODE_LENGTH = 32;
  localparam int NUM_TABLES      = 3;
  localparam int TAB_DEPTH       = NUM_TABLES * SYMBOLS;
  localparam int ADDR_W          = $clog2(TAB_DEPTH);

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 8;
  localparam int PAT_W    = 32;
  localparam int LEN_W    = 6;
  localparam int MASK_W   = PAT_W + 1;
  localparam int QUAL_W   = 4;

  // Bit accumulator: up to seven pending bits plus one full code.
  localparam int ACC_W = MAX_CODE_LENGTH + 7;
  localparam int CNT_W = $clog2(ACC_W + 1);

  // Reciprocal for the quantizer: q = (sample * RCP) >> RCP_SHIFT.
  localparam int RCP_SHIFT = 16;
  localparam int RCP_W     = RCP_SHIFT + 1;
  localparam int PROD_W    = SAMPLE_W + RCP_W;

  localparam logic [QUAL_W-1:0] QUALITY_RESET = 4'd10;

  // Command codes.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // Channel codes.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] length;
  } entry_t;

  // Commands from the sequencer to the bit packer.
  typedef struct packed {
    logic             append;
    logic             take;
    logic             clear;
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] length;
  } pk_ctrl_t;

  // Status from the bit packer.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic [7:0]       top_byte;
    logic [7:0]       flush_byte;
  } pk_stat_t;

  // Rounded-up reciprocal of the divisor 11 - quality, with quality saturated to 1..10.
  // Exact for all 8-bit samples since sample * error stays below 2^16.
  function automatic logic [RCP_W-1:0] recip(input logic [QUAL_W-1:0] quality);
    logic [RCP_W-1:0] r;
    case (quality) inside
      4'd0, 4'd1: r = 17'd6554;
      4'd2:       r = 17'd7282;
      4'd3:       r = 17'd8192;
      4'd4:       r = 17'd9363;
      4'd5:       r = 17'd10923;
      4'd6:       r = 17'd13108;
      4'd7:       r = 17'd16384;
      4'd8:       r = 17'd21846;
      4'd9:       r = 17'd32768;
      default:    r = 17'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] tab_addr(input logic [1:0] ch,
                                                 input logic [SAMPLE_W-1:0] sym);
    return ADDR_W'(ADDR_W'(ch) * ADDR_W'(SYMBOLS) + ADDR_W'(sym));
  endfunction

endpackage

// ===== rtl/qhp_quant.sv =====
module qhp_quant (
  input  logic                             clk,
  input  logic [qhp_pkg::SAMPLE_W-1:0]     sample,
  input  logic [qhp_pkg::QUAL_W-1:0]       quality,
  output logic [qhp_pkg::SAMPLE_W-1:0]     q
);

  logic [qhp_pkg::PROD_W-1:0] prod;

  // Division by a small divisor as a multiply by its reciprocal.
  assign prod = qhp_pkg::PROD_W'(sample) * qhp_pkg::PROD_W'(qhp_pkg::recip(quality));

  always_ff @(posedge clk) begin
    q <= prod[qhp_pkg::RCP_SHIFT +: qhp_pkg::SAMPLE_W];
  end

endmodule

// ===== rtl/qhp_packer.sv =====
module qhp_packer (
  input  logic              clk,
  input  logic              rst,
  input  qhp_pkg::pk_ctrl_t ctrl,
  output qhp_pkg::pk_stat_t stat
);

  logic [qhp_pkg::ACC_W-1:0] acc;
  logic [qhp_pkg::CNT_W-1:0] count;
  logic [qhp_pkg::CNT_W-1:0] top_shift;
  logic [qhp_pkg::ACC_W-1:0] top_word;
  logic [3:0]                pad_shift;

  // Only the low count bits of acc are meaningful; bits above are stale.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.append) begin
      acc   <= (acc << ctrl.length) | qhp_pkg::ACC_W'(ctrl.pattern);
      count <= count + qhp_pkg::CNT_W'(ctrl.length);
    end else if (ctrl.take) begin
      count <= count - qhp_pkg::CNT_W'(8);
    end
  end

  assign top_shift = count - qhp_pkg::CNT_W'(8);
  assign top_word  = acc >> top_shift;
  assign pad_shift = 4'd8 - {1'b0, count[2:0]};

  assign stat.count      = count;
  assign stat.full       = (count >= qhp_pkg::CNT_W'(8));
  assign stat.top_byte   = top_word[7:0];
  assign stat.flush_byte = 8'(acc[7:0] << pad_shift);

endmodule

// ===== rtl/quantized_huffman_pixel_packer.sv =====
// A load or an ignored command completes in the idle state; a flush with bits pending
// goes on to S_FINISH, which outputs its padded byte.
// An encode passes each channel through S_QUANT, S_READ, S_APPEND and S_DRAIN,
// then S_FINISH; each channel uses one quantizer, one table read and one shifter.
// Reset (synchronous, active high) starts a clearing pass over all 768 code table entries,
// during which no request is taken; quality returns to 10, pending bits to none.
module quantized_huffman_pixel_packer (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel.
  input  logic                           quality_valid,
  output logic                           quality_ready,
  input  logic [qhp_pkg::QUAL_W-1:0]     quality,
  // Input request channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     command,
  input  logic [1:0]                     channel,
  input  logic [7:0]                     symbol,
  input  logic [qhp_pkg::PAT_W-1:0]      code_pattern,
  input  logic [qhp_pkg::LEN_W-1:0]      code_length,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  // Output request channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           last_byte
);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_QUANT  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] ch, ch_next;
  logic [qhp_pkg::ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [qhp_pkg::QUAL_W-1:0] quality_level;

  // Latched pixel samples.
  logic [7:0] red_s, green_s, blue_s;

  // A finished byte waits in hold until it is known whether another byte
  // follows it, so that the last byte of a request can be marked.
  logic [7:0] hold, hold_next;
  logic       hold_valid, hold_valid_next;
  logic       out_valid_next;
  logic [7:0] out_byte_next;
  logic       last_byte_next;

  logic accept;
  logic out_free;
  logic can_push;
  logic load_ok;
  logic absent;

  // Code table memory, one entry per channel and symbol.
  qhp_pkg::entry_t            code_mem [qhp_pkg::TAB_DEPTH];
  qhp_pkg::entry_t            rd_data;
  qhp_pkg::entry_t            wr_data;
  logic [qhp_pkg::ADDR_W-1:0] wr_addr;
  logic [qhp_pkg::ADDR_W-1:0] rd_addr;
  logic                       wr_en;
  logic                       rd_en;

  logic [qhp_pkg::LEN_W-1:0]  len_sat;
  logic [qhp_pkg::MASK_W-1:0] pat_mask;

  logic [7:0] sample;
  logic [7:0] q;

  qhp_pkg::pk_ctrl_t pk_ctrl;
  qhp_pkg::pk_stat_t pk_stat;

  assign quality_ready = 1'b1;
  assign in_stall      = (state != S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign out_free      = !out_valid || !out_stall;
  assign can_push      = !hold_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_level <= qhp_pkg::QUALITY_RESET;
    end else if (quality_valid && quality_ready) begin
      quality_level <= quality;
    end
  end

  // Load entries keep at most MAX_CODE_LENGTH bits; pattern bits above the length are dropped.
  assign load_ok  = (channel < 2'(qhp_pkg::NUM_TABLES)) &&
                    ({1'b0, symbol} < 9'(qhp_pkg::SYMBOLS));
  assign len_sat  = (code_length > qhp_pkg::LEN_W'(qhp_pkg::MAX_CODE_LENGTH)) ?
                    qhp_pkg::LEN_W'(qhp_pkg::MAX_CODE_LENGTH) : code_length;
  assign pat_mask = (qhp_pkg::MASK_W'(1) << len_sat) - qhp_pkg::MASK_W'(1);

  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en           = accept && (command == qhp_pkg::CMD_LOAD) && load_ok;
      wr_addr         = qhp_pkg::tab_addr(channel, symbol);
      wr_data.pattern = code_pattern & pat_mask[qhp_pkg::PAT_W-1:0];
      wr_data.length  = len_sat;
    end
  end

  assign rd_en   = (state == S_READ);
  assign rd_addr = qhp_pkg::tab_addr(ch, q);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= code_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_s   <= red;
      green_s <= green;
      blue_s  <= blue;
    end
  end

  always_comb begin
    case (ch)
      qhp_pkg::CH_RED:   sample = red_s;
      qhp_pkg::CH_GREEN: sample = green_s;
      default:           sample = blue_s;
    endcase
  end

  // The quotient registers every cycle; it is steady while ch holds.
  qhp_quant u_quant (
    .clk     (clk),
    .sample  (sample),
    .quality (quality_level),
    .q       (q)
  );

  // A quantized value beyond the table has no code.
  assign absent = ({1'b0, q} >= 9'(qhp_pkg::SYMBOLS));

  qhp_packer u_packer (
    .clk  (clk),
    .rst  (rst),
    .ctrl (pk_ctrl),
    .stat (pk_stat)
  );

  always_comb begin
    state_next      = state;
    ch_next         = ch;
    clr_addr_next   = clr_addr;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    out_valid_next  = out_valid && out_stall;
    out_byte_next   = out_byte;
    last_byte_next  = last_byte;
    pk_ctrl.append  = 1'b0;
    pk_ctrl.take    = 1'b0;
    pk_ctrl.clear   = 1'b0;
    pk_ctrl.pattern = rd_data.pattern;
    pk_ctrl.length  = rd_data.length;

    unique case (state)
      S_CLEAR: begin
        clr_addr_next = clr_addr + qhp_pkg::ADDR_W'(1);
        if (clr_addr == qhp_pkg::ADDR_W'(qhp_pkg::TAB_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (command == qhp_pkg::CMD_ENCODE) begin
            ch_next    = qhp_pkg::CH_RED;
            state_next = S_QUANT;
          end else if (command == qhp_pkg::CMD_FLUSH && pk_stat.count != '0) begin
            // The padded partial byte is the only result of a flush.
            hold_next       = pk_stat.flush_byte;
            hold_valid_next = 1'b1;
            pk_ctrl.clear   = 1'b1;
            state_next      = S_FINISH;
          end
        end
      end
      S_QUANT: begin
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_APPEND;
      end
      S_APPEND: begin
        pk_ctrl.append = !absent;
        state_next     = S_DRAIN;
      end
      S_DRAIN: begin
        if (pk_stat.full) begin
          if (can_push) begin
            pk_ctrl.take = 1'b1;
            if (hold_valid) begin
              out_valid_next = 1'b1;
              out_byte_next  = hold;
              last_byte_next = 1'b0;
            end
            hold_next       = pk_stat.top_byte;
            hold_valid_next = 1'b1;
          end
        end else if (ch == qhp_pkg::CH_BLUE) begin
          state_next = S_FINISH;
        end else begin
          ch_next    = ch + 2'd1;
          state_next = S_QUANT;
        end
      end
      S_FINISH: begin
        if (!hold_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_byte_next   = hold;
          last_byte_next  = 1'b1;
          hold_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ch         <= qhp_pkg::CH_RED;
      clr_addr   <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ch         <= ch_next;
      clr_addr   <= clr_addr_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold      <= hold_next;
    out_byte  <= out_byte_next;
    last_byte <= last_byte_next;
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package leaves unnamed: the fourth command and the fourth table
  // index are both ignored by the block.
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [1:0] CH_NONE     = 2'd3;

  // The quantizer divides each sample by DIVISOR_BASE minus the quality, with the
  // quality saturated to QUALITY_MIN..QUALITY_MAX.
  localparam int DIVISOR_BASE = 11;
  localparam int QUALITY_MIN  = 1;
  localparam int QUALITY_MAX  = 10;

  // Symbols in the small set that random loads and random pixels both aim at.
  localparam int HOT_SYMBOLS = 8;

  // After the last expected byte, an encode that adds no full byte can still be
  // running, so allow a settling margin of SETTLE_CYCLES before a register write.
  localparam int SETTLE_CYCLES = 40;

  // The slowest run is well under 2 ms, including the table clear.
  localparam int RUN_LIMIT_NS = 10_000_000;

  localparam int RANDOM_REQUESTS_PER_PHASE = 58;

  typedef struct packed {
    logic [1:0]                command;
    logic [1:0]                channel;
    logic [7:0]                symbol;
    logic [qhp_pkg::PAT_W-1:0] code_pattern;
    logic [qhp_pkg::LEN_W-1:0] code_length;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
  } pixel_request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // Everything the testbench drives starts at a known value.
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       quality_valid = 1'b0;
  logic                       quality_ready;
  logic [qhp_pkg::QUAL_W-1:0] quality = qhp_pkg::QUALITY_RESET;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 command = qhp_pkg::CMD_LOAD;
  logic [1:0]                 channel = qhp_pkg::CH_RED;
  logic [7:0]                 symbol = '0;
  logic [qhp_pkg::PAT_W-1:0]  code_pattern = '0;
  logic [qhp_pkg::LEN_W-1:0]  code_length = '0;
  logic [7:0]                 red = '0;
  logic [7:0]                 green = '0;
  logic [7:0]                 blue = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [7:0]                 out_byte;
  logic                       last_byte;

  // Percentages of cycles in which the sender holds back a request and the
  // receiver stalls the output.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;

  // Our own copy of the block's state: the three code tables, the bits that
  // have not yet filled a byte, and the quality register.
  logic [qhp_pkg::PAT_W-1:0]  code_pat[qhp_pkg::NUM_TABLES][qhp_pkg::SYMBOLS];
  logic [qhp_pkg::LEN_W-1:0]  code_len[qhp_pkg::NUM_TABLES][qhp_pkg::SYMBOLS];
  logic [7:0]                 stream_bits;
  int                         stream_count;
  logic [qhp_pkg::QUAL_W-1:0] cur_quality;

  // Bytes produced by the request being predicted, and all bytes still owed.
  logic [7:0]   new_bytes[$];
  stream_byte_t expected_bytes[$];

  quantized_huffman_pixel_packer u_top (
    .clk          (clk),
    .rst          (rst),
    .quality_valid(quality_valid),
    .quality_ready(quality_ready),
    .quality      (quality),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .channel      (channel),
    .symbol       (symbol),
    .code_pattern (code_pattern),
    .code_length  (code_length),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_byte    (last_byte)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The receiver stalls at random; one assignment per edge keeps it race free.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic int quality_divisor(input logic [qhp_pkg::QUAL_W-1:0] q);
    int qv;
    qv = q;
    if (qv < QUALITY_MIN) qv = QUALITY_MIN;
    if (qv > QUALITY_MAX) qv = QUALITY_MAX;
    return DIVISOR_BASE - qv;
  endfunction

  // Appends a code to the bit stream, most significant bit first, and collects
  // every byte that it completes.
  function automatic void shift_in_code(input logic [qhp_pkg::PAT_W-1:0] pat,
                                        input logic [qhp_pkg::LEN_W-1:0] len);
    for (int i = int'(len); i > 0; i--) begin
      stream_bits = {stream_bits[6:0], pat[i-1]};
      stream_count++;
      if (stream_count == 8) begin
        new_bytes.push_back(stream_bits);
        stream_bits = '0;
        stream_count = 0;
      end
    end
  endfunction

  // Updates the state copy for one accepted request and queues the bytes it
  // must produce, with the last one of them marked.
  function automatic void predict_request(input pixel_request_t r);
    logic [qhp_pkg::LEN_W-1:0] len;
    logic [qhp_pkg::PAT_W-1:0] pat;
    logic [7:0]                samples[qhp_pkg::NUM_TABLES];
    int                        divisor;
    int                        qv;
    new_bytes.delete();
    case (r.command)
      qhp_pkg::CMD_LOAD: begin
        if (r.channel != CH_NONE && int'(r.symbol) < qhp_pkg::SYMBOLS) begin
          // Overlong codes are cut to the longest length the tables hold, and
          // pattern bits above the length are dropped.
          len = (int'(r.code_length) > qhp_pkg::MAX_CODE_LENGTH) ?
                qhp_pkg::LEN_W'(qhp_pkg::MAX_CODE_LENGTH) : r.code_length;
          pat = r.code_pattern;
          if (len < qhp_pkg::PAT_W) begin
            pat &= (qhp_pkg::PAT_W'(1) << len) - qhp_pkg::PAT_W'(1);
          end
          code_pat[r.channel][r.symbol] = pat;
          code_len[r.channel][r.symbol] = len;
        end
      end
      qhp_pkg::CMD_ENCODE: begin
        divisor = quality_divisor(cur_quality);
        samples = '{r.red, r.green, r.blue};
        for (int ch = 0; ch < qhp_pkg::NUM_TABLES; ch++) begin
          qv = int'(samples[ch]) / divisor;
          // An unloaded symbol has length zero and adds nothing.
          if (qv < qhp_pkg::SYMBOLS) shift_in_code(code_pat[ch][qv], code_len[ch][qv]);
        end
      end
      qhp_pkg::CMD_FLUSH: begin
        // A flush with nothing pending produces no byte.
        if (stream_count > 0) begin
          new_bytes.push_back(stream_bits << (8 - stream_count));
          stream_bits = '0;
          stream_count = 0;
        end
      end
      default: begin
      end
    endcase
    foreach (new_bytes[i]) begin
      expected_bytes.push_back('{data: new_bytes[i], last: (i == new_bytes.size() - 1)});
    end
  endfunction

  // Every accepted output byte is checked against the oldest one still owed.
  always @(posedge clk) begin
    stream_byte_t exp_byte;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %0h (last_byte %0b)", out_byte, last_byte);
        fail_count++;
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (out_byte !== exp_byte.data) begin
          $error("out_byte: expected %0h, got %0h", exp_byte.data, out_byte);
          fail_count++;
        end
        if (last_byte !== exp_byte.last) begin
          $error("last_byte: expected %0b, got %0b", exp_byte.last, last_byte);
          fail_count++;
        end
      end
    end
  end

  // Sends one request. It is entered and left at a rising edge; valid stays high
  // on return so that a following request can go out back to back.
  task automatic send_request(input pixel_request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= r.command;
    channel      <= r.channel;
    symbol       <= r.symbol;
    code_pattern <= r.code_pattern;
    code_length  <= r.code_length;
    red          <= r.red;
    green        <= r.green;
    blue         <= r.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(r);
  endtask

  task automatic send_fields(input logic [1:0] cmd, input logic [1:0] ch,
                             input logic [7:0] sym,
                             input logic [qhp_pkg::PAT_W-1:0] pat,
                             input logic [qhp_pkg::LEN_W-1:0] len, input logic [7:0] r_s,
                             input logic [7:0] g_s, input logic [7:0] b_s);
    send_request('{command: cmd, channel: ch, symbol: sym, code_pattern: pat,
                   code_length: len, red: r_s, green: g_s, blue: b_s});
  endtask

  // Stops sending, waits until every owed byte has arrived, then lets the block
  // finish any request that produces no byte.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_quality(input logic [qhp_pkg::QUAL_W-1:0] q);
    quality_valid <= 1'b1;
    quality       <= q;
    @(posedge clk);
    while (!quality_ready) @(posedge clk);
    quality_valid <= 1'b0;
    cur_quality = q;
  endtask

  function automatic int hot_symbol(input int divisor);
    int top;
    top = 255 / divisor;
    if (top > HOT_SYMBOLS - 1) top = HOT_SYMBOLS - 1;
    return $urandom_range(top, 0);
  endfunction

  // Mostly samples that quantize onto the hot symbols, some fully random.
  function automatic logic [7:0] pick_sample(input int divisor);
    int s;
    if ($urandom_range(4) == 0) return 8'($urandom);
    s = hot_symbol(divisor) * divisor + $urandom_range(divisor - 1, 0);
    if (s > 255) s = 255;
    return 8'(s);
  endfunction

  // Flushes, ignored commands and a load to the unnamed table index with nothing
  // pending or loaded, and encodes of pixels none of whose symbols has a code.
  task automatic test_empty_state();
    send_fields(qhp_pkg::CMD_FLUSH, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd0, 8'd0, 8'd0);
    send_fields(CMD_IGNORED, qhp_pkg::CH_BLUE, 8'hff, '1, '1, 8'hff, 8'hff, 8'hff);
    send_fields(qhp_pkg::CMD_ENCODE, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd17, 8'd200, 8'd255);
    send_fields(qhp_pkg::CMD_LOAD, CH_NONE, 8'd17, '1, 6'd4, 8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_ENCODE, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd17, 8'd17, 8'd17);
    send_fields(qhp_pkg::CMD_FLUSH, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd0, 8'd0, 8'd0);
  endtask

  // At the reset quality every sample is its own symbol. Covers the longest
  // codes, an overlong length, pattern bits above the length, a zero length and
  // the largest number of bytes one pixel can produce.
  task automatic test_code_extremes();
    send_fields(qhp_pkg::CMD_LOAD, qhp_pkg::CH_RED, 8'd255, '1, 6'd32, 8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_LOAD, qhp_pkg::CH_GREEN, 8'd0, '1, 6'd63, 8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_LOAD, qhp_pkg::CH_BLUE, 8'd128, '1, 6'd5, 8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_ENCODE, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd255, 8'd0, 8'd128);
    send_fields(qhp_pkg::CMD_FLUSH, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_LOAD, qhp_pkg::CH_RED, 8'd0, 32'h0, 6'd1, 8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_LOAD, qhp_pkg::CH_GREEN, 8'd255, 32'hffff_ffff, 6'd0,
                8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_LOAD, qhp_pkg::CH_BLUE, 8'd255, 32'haaaa_aaaa, 6'd32,
                8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_LOAD, qhp_pkg::CH_BLUE, 8'd0, 32'h0, 6'd32, 8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_ENCODE, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd0, 8'd255, 8'd255);
    send_fields(qhp_pkg::CMD_ENCODE, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd255, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_FLUSH, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd0, 8'd0, 8'd0);
  endtask

  // A quality of zero acts as the lowest quality and one above the range acts
  // as the highest.
  task automatic test_quality_saturation();
    wait_for_drain();
    write_quality(4'd0);
    send_fields(qhp_pkg::CMD_LOAD, qhp_pkg::CH_RED, 8'd25, 32'h2, 6'd2, 8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_LOAD, qhp_pkg::CH_GREEN, 8'd25, 32'h1, 6'd3, 8'd0, 8'd0, 8'd0);
    send_fields(qhp_pkg::CMD_ENCODE, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd255, 8'd250, 8'd9);
    wait_for_drain();
    write_quality(4'd15);
    send_fields(qhp_pkg::CMD_ENCODE, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd25, 8'd25, 8'd255);
    send_fields(qhp_pkg::CMD_FLUSH, qhp_pkg::CH_RED, 8'd0, '0, '0, 8'd0, 8'd0, 8'd0);
  endtask

  // Random traffic at one quality setting. Loads and pixels both aim mostly at
  // a few hot symbols so that most pixels find loaded codes, and most codes are
  // short so that bytes come out at a steady pace. Every field not overridden
  // keeps fully random bits. Requests the block ignores are not counted.
  task automatic test_random_traffic(input logic [qhp_pkg::QUAL_W-1:0] q,
                                     input int send_pct, input int recv_pct);
    pixel_request_t r;
    int             counted;
    int             pick;
    int             divisor;
    wait_for_drain();
    write_quality(q);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    divisor = quality_divisor(q);
    counted = 0;
    while (counted < RANDOM_REQUESTS_PER_PHASE) begin
      r = '{command: 2'($urandom), channel: 2'($urandom), symbol: 8'($urandom),
            code_pattern: qhp_pkg::PAT_W'($urandom),
            code_length: qhp_pkg::LEN_W'($urandom),
            red: 8'($urandom), green: 8'($urandom), blue: 8'($urandom)};
      pick = $urandom_range(99);
      if (pick < 38) begin
        r.command = qhp_pkg::CMD_LOAD;
        if ($urandom_range(19) != 0) r.channel = 2'($urandom_range(qhp_pkg::NUM_TABLES - 1));
        if ($urandom_range(4) != 0) r.symbol = 8'(hot_symbol(divisor));
        if ($urandom_range(9) != 0) r.code_length = qhp_pkg::LEN_W'($urandom_range(12, 1));
      end else if (pick < 85) begin
        r.command = qhp_pkg::CMD_ENCODE;
        r.red   = pick_sample(divisor);
        r.green = pick_sample(divisor);
        r.blue  = pick_sample(divisor);
      end else if (pick < 95) begin
        r.command = qhp_pkg::CMD_FLUSH;
      end else begin
        r.command = CMD_IGNORED;
      end
      send_request(r);
      if (r.command != CMD_IGNORED &&
          !(r.command == qhp_pkg::CMD_LOAD && r.channel == CH_NONE)) begin
        counted++;
      end
    end
  endtask

  initial begin
    // State after reset: empty tables, no pending bits, quality at its reset value.
    foreach (code_len[ch, s]) begin
      code_pat[ch][s] = '0;
      code_len[ch][s] = '0;
    end
    stream_bits  = '0;
    stream_count = 0;
    cur_quality  = qhp_pkg::QUALITY_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Sender idles in 31% of cycles and the receiver in 45% first, then the
    // other way round, and then neither side idles.
    send_idle_pct = 31;
    recv_idle_pct = 45;
    test_empty_state();
    test_code_extremes();
    test_quality_saturation();
    test_random_traffic(4'd1, 31, 45);
    test_random_traffic(4'd10, 45, 31);
    test_random_traffic(4'd15, 0, 0);
    test_random_traffic(4'd5, 0, 0);
    wait_for_drain();

    if (fail_count == 0) begin
      $display("quantized_huffman_pixel_packer: match");
    end else begin
      $display("quantized_huffman_pixel_packer: mismatch");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT_NS);
    $display("quantized_huffman_pixel_packer: mismatch");
    $finish;
  end

endmodule
